// ===== sv/sgdct_pkg.sv =====
`timescale 1ns / 1ps
package sgdct_pkg;

  localparam logic [1:0] CMD_PUSH_DESC = 2'd0;
  localparam logic [1:0] CMD_PUSH_JOB  = 2'd1;
  localparam logic [1:0] CMD_TRANSFER  = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] desc_addr;
    logic [31:0] desc_len;
    logic [6:0]  job_blocks;
    logic [31:0] bytes_done;
  } cmd_word_t;

  typedef struct packed {
    logic [5:0] jobs_completed;
    logic [6:0] blocks_retired;
    logic [5:0] pending_jobs;
    logic [6:0] pending_blocks;
    logic       error_flag;
  } result_word_t;

endpackage

// ===== sv/sgdct_desc_cell.sv =====
`timescale 1ns / 1ps
// one descriptor slot; the row shifts toward slot 0 when the head retires
module sgdct_desc_cell
  import sgdct_pkg::*;
(
  input  logic        clk,
  input  logic        load,
  input  logic [31:0] load_addr,
  input  logic [31:0] load_len,
  input  logic        shift,
  input  logic [31:0] nbr_addr,
  input  logic [31:0] nbr_len,
  input  logic        adjust,
  input  logic [31:0] adj_bytes,
  output logic [31:0] addr,
  output logic [31:0] len
);

  always_ff @(posedge clk) begin
    if (load) begin
      addr <= load_addr;
      len  <= load_len;
    end else if (shift) begin
      addr <= nbr_addr;
      len  <= nbr_len;
    end else if (adjust) begin
      addr <= addr + adj_bytes;
      len  <= len - adj_bytes;
    end
  end

endmodule

// ===== sv/sgdct_job_cell.sv =====
`timescale 1ns / 1ps
module sgdct_job_cell
  import sgdct_pkg::*;
(
  input  logic       clk,
  input  logic       load,
  input  logic [6:0] load_cnt,
  input  logic       shift,
  input  logic [6:0] nbr_cnt,
  input  logic       adjust,
  input  logic [6:0] adj_cnt,
  output logic [6:0] cnt
);

  always_ff @(posedge clk) begin
    if (load) begin
      cnt <= load_cnt;
    end else if (shift) begin
      cnt <= nbr_cnt;
    end else if (adjust) begin
      cnt <= cnt - adj_cnt;
    end
  end

endmodule

// ===== sv/sg_descriptor_completion_tracker.sv =====
`timescale 1ns / 1ps
// scatter-gather descriptor completion tracker
// command channel: start/busy/cmd; a word is taken when start is high and busy low
// result channel: result with a one-cycle strobe; the receiver cannot stall it
// descriptors and jobs sit in two rows of cells, slot 0 always the head;
// retiring the head shifts the whole row one cell toward slot 0 per cycle
// push commands: the result is registered out after the S_EXEC and S_DONE states
// transfer: after S_EXEC, S_DESC retires head descriptors and S_JOB pops jobs before S_DONE;
// this walk of the two rows sets the rate
// reset clears the fill counts and the sequencer; cell contents need none
// busy stays high from acceptance until the cycle the result strobes
module sg_descriptor_completion_tracker
  import sgdct_pkg::*;
#(
  parameter int DESC_DEPTH = 64,
  parameter int JOB_DEPTH  = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  cmd_word_t    cmd,
  output logic         strobe,
  output result_word_t result
);

  localparam int DCW = $clog2(DESC_DEPTH + 1);
  localparam int JCW = $clog2(JOB_DEPTH + 1);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_DESC, S_JOB, S_DONE} state_t;

  state_t         state;
  cmd_word_t      cw;
  logic [DCW-1:0] desc_count;
  logic [JCW-1:0] job_fill;
  logic [31:0]    nbytes;
  logic [6:0]     blk;
  logic [6:0]     jcnt;
  logic [5:0]     jobs;
  logic           err;

  logic [31:0] d_addr [DESC_DEPTH];
  logic [31:0] d_len  [DESC_DEPTH];
  logic [6:0]  j_cnt  [JOB_DEPTH];

  logic d_shift, d_adjust, j_shift, j_adjust, d_push, j_push;

  always_comb begin
    d_push   = (state == S_EXEC) && (cw.cmd == CMD_PUSH_DESC) &&
               (desc_count < DCW'(DESC_DEPTH));
    j_push   = (state == S_EXEC) && (cw.cmd == CMD_PUSH_JOB) &&
               (job_fill < JCW'(JOB_DEPTH));
    d_shift  = (state == S_DESC) && (desc_count != '0) && (nbytes >= d_len[0]);
    d_adjust = (state == S_DESC) && (desc_count != '0) && (nbytes < d_len[0]);
    j_shift  = (state == S_JOB) && (job_fill != '0) && (j_cnt[0] <= jcnt);
    j_adjust = (state == S_JOB) && (job_fill != '0) && (j_cnt[0] > jcnt);
  end

  for (genvar i = 0; i < DESC_DEPTH; i++) begin : g_desc
    logic [31:0] na, nl;
    if (i == DESC_DEPTH - 1) begin : g_last
      assign na = d_addr[i];
      assign nl = d_len[i];
    end else begin : g_mid
      assign na = d_addr[i+1];
      assign nl = d_len[i+1];
    end
    sgdct_desc_cell u_cell (
      .clk(clk),
      .load(d_push && (desc_count == DCW'(i))),
      .load_addr(cw.desc_addr), .load_len(cw.desc_len),
      .shift(d_shift), .nbr_addr(na), .nbr_len(nl),
      .adjust(d_adjust && (i == 0)), .adj_bytes(nbytes),
      .addr(d_addr[i]), .len(d_len[i])
    );
  end

  for (genvar i = 0; i < JOB_DEPTH; i++) begin : g_job
    logic [6:0] nc;
    if (i == JOB_DEPTH - 1) begin : g_last
      assign nc = j_cnt[i];
    end else begin : g_mid
      assign nc = j_cnt[i+1];
    end
    sgdct_job_cell u_cell (
      .clk(clk),
      .load(j_push && (job_fill == JCW'(i))),
      .load_cnt(cw.job_blocks),
      .shift(j_shift), .nbr_cnt(nc),
      .adjust(j_adjust && (i == 0)), .adj_cnt(jcnt),
      .cnt(j_cnt[i])
    );
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      desc_count <= '0;
      job_fill   <= '0;
      strobe     <= 1'b0;
    end else begin
      strobe <= (state == S_DONE);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cw    <= cmd;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          nbytes <= cw.bytes_done;
          blk    <= '0;
          jobs   <= '0;
          err    <= ((cw.cmd == CMD_PUSH_DESC) && !d_push) ||
                    ((cw.cmd == CMD_PUSH_JOB) && !j_push);
          if (d_push) desc_count <= desc_count + 1'b1;
          if (j_push) job_fill <= job_fill + 1'b1;
          state  <= (cw.cmd == CMD_TRANSFER) ? S_DESC : S_DONE;
        end
        S_DESC: begin
          if (d_shift) begin
            nbytes     <= nbytes - d_len[0];
            desc_count <= desc_count - 1'b1;
            blk        <= blk + 1'b1;
          end else begin
            // partial head was adjusted by the cell; leftovers with no descriptor flag
            if (desc_count == '0 && nbytes != '0) err <= 1'b1;
            jcnt  <= blk;
            state <= S_JOB;
          end
        end
        S_JOB: begin
          if (j_shift) begin
            jcnt     <= jcnt - j_cnt[0];
            job_fill <= job_fill - 1'b1;
            jobs     <= jobs + 1'b1;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          result.jobs_completed <= jobs;
          result.blocks_retired <= blk;
          result.pending_jobs   <= 6'(job_fill);
          result.pending_blocks <= 7'(desc_count);
          result.error_flag     <= err;
          state                 <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== bench/sgdct_checker.sv =====
`timescale 1ns / 1ps
module sgdct_checker
  import sgdct_pkg::*;
#(
  parameter int DESC_DEPTH = 64,
  parameter int JOB_DEPTH  = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic         busy,
  input  cmd_word_t    cmd,
  input  logic         strobe,
  input  result_word_t result,
  output int           fail_count,
  output int           pending_words,
  output int           transfers_seen,
  output int           jobs_popped_total
);

  // predictor copy of the two fifos
  logic [31:0] addr_mem [DESC_DEPTH];
  logic [31:0] len_mem  [DESC_DEPTH];
  logic [6:0]  jcnt_mem [JOB_DEPTH];
  int unsigned dhead, dfill, jhead, jfill;

  result_word_t expected_q [$];

  assign pending_words = expected_q.size();

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %0t: %s got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic result_word_t retire_predict(input cmd_word_t w);
    result_word_t r;
    int unsigned blk, jobs, left;
    logic [31:0] nb;
    blk = 0;
    jobs = 0;
    r = '0;
    case (w.cmd)
      CMD_PUSH_DESC: begin
        if (dfill >= DESC_DEPTH) begin
          r.error_flag = 1'b1;
        end else begin
          addr_mem[(dhead + dfill) % DESC_DEPTH] = w.desc_addr;
          len_mem[(dhead + dfill) % DESC_DEPTH]  = w.desc_len;
          dfill++;
        end
      end
      CMD_PUSH_JOB: begin
        if (jfill >= JOB_DEPTH) begin
          r.error_flag = 1'b1;
        end else begin
          jcnt_mem[(jhead + jfill) % JOB_DEPTH] = w.job_blocks;
          jfill++;
        end
      end
      CMD_TRANSFER: begin
        nb = w.bytes_done;
        while (dfill > 0 && nb >= len_mem[dhead]) begin
          nb -= len_mem[dhead];
          dhead = (dhead + 1) % DESC_DEPTH;
          dfill--;
          blk++;
        end
        if (dfill > 0) begin
          addr_mem[dhead] += nb;
          len_mem[dhead]  -= nb;
        end else if (nb != 0) begin
          r.error_flag = 1'b1;
        end
        left = blk;
        while (jfill > 0 && jcnt_mem[jhead] <= left) begin
          left -= jcnt_mem[jhead];
          jhead = (jhead + 1) % JOB_DEPTH;
          jfill--;
          jobs++;
        end
        if (jfill > 0) jcnt_mem[jhead] -= left[6:0];
      end
      default: ;
    endcase
    r.jobs_completed = jobs[5:0];
    r.blocks_retired = blk[6:0];
    r.pending_jobs   = jfill[5:0];
    r.pending_blocks = dfill[6:0];
    return r;
  endfunction

  always @(posedge clk) begin
    result_word_t want;
    if (rst) begin
      dhead <= 0;
      dfill <= 0;
      jhead <= 0;
      jfill <= 0;
      fail_count <= 0;
      transfers_seen <= 0;
      jobs_popped_total <= 0;
      expected_q.delete();
    end else begin
      if (start && !busy) begin
        if (cmd.cmd == CMD_TRANSFER) transfers_seen++;
        want = retire_predict(cmd);
        jobs_popped_total += want.jobs_completed;
        expected_q.push_back(want);
      end
      if (strobe) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result word", 1, 0);
        end else begin
          want = expected_q.pop_front();
          if (result.jobs_completed != want.jobs_completed)
            report_mismatch("jobs_completed", result.jobs_completed, want.jobs_completed);
          if (result.blocks_retired != want.blocks_retired)
            report_mismatch("blocks_retired", result.blocks_retired, want.blocks_retired);
          if (result.pending_jobs != want.pending_jobs)
            report_mismatch("pending_jobs", result.pending_jobs, want.pending_jobs);
          if (result.pending_blocks != want.pending_blocks)
            report_mismatch("pending_blocks", result.pending_blocks, want.pending_blocks);
          if (result.error_flag != want.error_flag)
            report_mismatch("error_flag", result.error_flag, want.error_flag);
        end
      end
    end
  end

endmodule

// ===== bench/tb_sg_descriptor_completion_tracker.sv =====
`timescale 1ns / 1ps
module tb_sg_descriptor_completion_tracker;
  import sgdct_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         start = 1'b0;
  logic         busy;
  cmd_word_t    cmd = '0;
  logic         strobe;
  result_word_t result;
  int           fail_count, pending_words, transfers_seen, jobs_popped_total;

  sg_descriptor_completion_tracker dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .strobe(strobe), .result(result)
  );

  sgdct_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .strobe(strobe), .result(result), .fail_count(fail_count),
    .pending_words(pending_words), .transfers_seen(transfers_seen),
    .jobs_popped_total(jobs_popped_total)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 16);
      default: return $urandom;
    endcase
  endfunction

  // one word through the start/busy handshake, with optional idle burst first
  task automatic send_word(input cmd_word_t w, input bit allow_idle);
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    // busy is settled at the falling edge
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    start <= 1'b1;
    cmd   <= w;
    // busy is low, so the word is taken at this edge
    @(posedge clk);
    start <= 1'b0;
  endtask

  task automatic push_desc(input logic [31:0] a, input logic [31:0] l, input bit idle);
    cmd_word_t w;
    w = '0;
    w.cmd = CMD_PUSH_DESC;
    w.desc_addr = a;
    w.desc_len = l;
    w.job_blocks = 7'($urandom);
    w.bytes_done = $urandom;
    send_word(w, idle);
  endtask

  task automatic push_job(input logic [6:0] n, input bit idle);
    cmd_word_t w;
    w = '0;
    w.cmd = CMD_PUSH_JOB;
    w.job_blocks = n;
    w.desc_addr = $urandom;
    w.desc_len = $urandom;
    send_word(w, idle);
  endtask

  task automatic send_transfer(input logic [31:0] nb, input bit idle);
    cmd_word_t w;
    w = '0;
    w.cmd = CMD_TRANSFER;
    w.bytes_done = nb;
    w.desc_addr = $urandom;
    w.desc_len = $urandom;
    w.job_blocks = 7'($urandom);
    send_word(w, idle);
  endtask

  initial begin
    cmd_word_t w;
    int i, k, nd, nb;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty transfers, zero length and zero count heads, overflow
    send_transfer(32'd0, 0);
    send_transfer(32'hFFFF_FFFF, 0);
    push_desc(32'hFFFF_FFF0, 32'd0, 0);
    push_job(7'd0, 0);
    send_transfer(32'd0, 0);
    push_desc(32'hFFFF_FFF0, 32'h100, 0);
    push_job(7'd127, 0);
    send_transfer(32'h20, 0);
    send_transfer(32'hE0, 0);
    w = '0;
    w.cmd = 2'd3;
    w.desc_addr = '1;
    w.desc_len = '1;
    w.job_blocks = '1;
    w.bytes_done = '1;
    send_word(w, 0);
    for (i = 0; i < 65; i++) push_desc($urandom, 32'hFFFF_FFFF, 0);
    for (i = 0; i < 33; i++) push_job(7'd64, 0);
    send_transfer(32'hFFFF_FFFF, 0);
    // drain the descriptor row
    for (i = 0; i < 70; i++) send_transfer(32'hFFFF_FFFF, 0);
    for (i = 0; i < 40; i++) begin
      push_desc(32'd0, 32'd0, 0);
    end
    for (i = 0; i < 40; i++) send_transfer(32'd0, 0);
    // pause until every expected word has come back
    while (pending_words != 0) @(posedge clk);

    // random: mostly well-formed jobs of small descriptors then transfers
    for (i = 0; i < 150; i++) begin
      bit idle;
      idle = (i < 130);
      k = $urandom_range(0, 9);
      if (k < 3) begin
        nd = $urandom_range(0, 4);
        push_job(($urandom_range(0, 19) == 0) ? 7'($urandom) : 7'(nd), idle);
        for (nb = 0; nb < nd; nb++) push_desc(rand_word(), $urandom_range(0, 40), idle);
      end else if (k < 8) begin
        send_transfer(($urandom_range(0, 9) == 0) ? rand_word() : $urandom_range(0, 90), idle);
      end else if (k == 8) begin
        push_desc(rand_word(), rand_word(), idle);
      end else begin
        w = '0;
        w.cmd = 2'($urandom_range(0, 3));
        w.desc_addr = $urandom;
        w.desc_len = $urandom;
        w.job_blocks = 7'($urandom);
        w.bytes_done = $urandom;
        send_word(w, idle);
      end
    end

    while (pending_words != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d transfers, %0d jobs completed, pushes to full and unknown cmds",
             transfers_seen, jobs_popped_total);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
